/* rtl/core/tcew_pkg.sv */
`default_nettype none

package tcew_pkg;

    // Field widths fixed by the port definition
    localparam int COL_W    = 7;
    localparam int ROW_W    = 5;
    localparam int ADDR_W   = 11;
    localparam int CHAR_W   = 8;
    localparam int ATTR_W   = 8;
    localparam int PARAM_W  = 8;

    // Largest screen width the column register can hold
    localparam int COL_LIMIT = 1 << COL_W;

    // Default geometry
    localparam int COLUMNS_DEF   = 80;
    localparam int ROWS_DEF      = 25;
    localparam int TAB_WIDTH_DEF = 8;

    // Attribute after reset
    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_ESC    = 8'h1B;
    localparam logic [CHAR_W-1:0] CH_LBRACK = 8'h5B;
    localparam logic [CHAR_W-1:0] CH_J      = 8'h4A;
    localparam logic [CHAR_W-1:0] CH_E      = 8'h45;
    localparam logic [CHAR_W-1:0] CH_H      = 8'h48;
    localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3B;
    localparam logic [CHAR_W-1:0] CH_BS     = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
    localparam logic [CHAR_W-1:0] CH_NL     = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_0      = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9      = 8'h39;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;

    // Saturation value of a decimal parameter
    localparam logic [PARAM_W-1:0] PARAM_MAX = 8'hFF;

    typedef enum logic [1:0] {
        KIND_CELL   = 2'd0,
        KIND_SCROLL = 2'd1,
        KIND_CLEAR  = 2'd2,
        KIND_ECHO   = 2'd3
    } cmd_kind_t;

    typedef enum logic [1:0] {
        PH_TEXT = 2'd0,
        PH_ESC  = 2'd1,
        PH_P1   = 2'd2,
        PH_P2   = 2'd3
    } esc_phase_t;

    typedef enum logic [3:0] {
        CC_OTHER,
        CC_CR,
        CC_BS,
        CC_TAB,
        CC_NL,
        CC_ESC,
        CC_LBRACK,
        CC_DIGIT,
        CC_SEMI,
        CC_J,
        CC_E,
        CC_H
    } ch_class_t;

    typedef enum logic [2:0] {
        CUR_HOLD,
        CUR_ADV,
        CUR_BACK,
        CUR_NEWLINE,
        CUR_PARAM
    } cur_op_t;

    typedef enum logic [2:0] {
        PAR_HOLD,
        PAR_CLR1,
        PAR_CLR2,
        PAR_DIG1,
        PAR_DIG2
    } par_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_TAB,
        ST_BS_EMIT,
        ST_SCROLL
    } ctrl_state_t;

    // Controller to datapath
    typedef struct packed {
        logic       load_char;
        logic       set_phase;
        esc_phase_t phase_val;
        cur_op_t    cur_op;
        par_op_t    par_op;
        logic       emit;
        cmd_kind_t  emit_kind;
        logic       use_space;
        logic       emit_last;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        ch_class_t  ch_class;
        esc_phase_t phase;
        logic       col_zero;
        logic       row_zero;
        logic       row_last;
        logic       wrap_next;
        logic       tab_stop_next;
        logic       out_free;
    } dp_status_t;

    localparam dp_cmd_t CMD_IDLE = '{
        load_char: 1'b0,
        set_phase: 1'b0,
        phase_val: PH_TEXT,
        cur_op:    CUR_HOLD,
        par_op:    PAR_HOLD,
        emit:      1'b0,
        emit_kind: KIND_CELL,
        use_space: 1'b0,
        emit_last: 1'b0
    };

endpackage

`default_nettype wire

/* rtl/core/text_console_escape_writer.sv */
`default_nettype none

// Channel   Handshake               Payload
// -------   ---------------------   ---------------------------------------------
// input     char_valid/char_ready   char_in
// config    cfg_valid/cfg_ready     text_attr
// output    cmd_valid/cmd_ready     cmd_kind, cell_addr, char_code, cell_attr,
//                                   cursor_col, cursor_row, last
//
// A byte is accepted in the idle state and decoded in the decode state, which
// emits its word. A backspace that moves then blanks its cell in a state of its
// own; a tab writes its spaces in the tab state; a tab, wrap or newline that
// scrolls goes on to the scroll state. Words leave one at a time through a
// single output register. Reset clears cursor, parser and parameters and sets
// the attribute to 7. A held output word stalls emission; the next byte is
// still taken while the last word of the previous one waits.

module text_console_escape_writer #(
    parameter int COLUMNS   = tcew_pkg::COLUMNS_DEF,
    parameter int ROWS      = tcew_pkg::ROWS_DEF,
    parameter int TAB_WIDTH = tcew_pkg::TAB_WIDTH_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         char_valid,
    output logic                              char_ready,
    input  wire logic [tcew_pkg::CHAR_W-1:0]  char_in,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [tcew_pkg::ATTR_W-1:0]  text_attr,
    output logic                              cmd_valid,
    input  wire logic                         cmd_ready,
    output logic [1:0]                        cmd_kind,
    output logic [tcew_pkg::ADDR_W-1:0]       cell_addr,
    output logic [tcew_pkg::CHAR_W-1:0]       char_code,
    output logic [tcew_pkg::ATTR_W-1:0]       cell_attr,
    output logic [tcew_pkg::COL_W-1:0]        cursor_col,
    output logic [tcew_pkg::ROW_W-1:0]        cursor_row,
    output logic                              last
);

    tcew_pkg::dp_cmd_t    dp_cmd;
    tcew_pkg::dp_status_t dp_st;

    // Attribute writes are always taken
    assign cfg_ready = 1'b1;

    tcew_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .st         (dp_st),
        .cmd        (dp_cmd)
    );

    tcew_dp #(
        .COLUMNS   (COLUMNS),
        .ROWS      (ROWS),
        .TAB_WIDTH (TAB_WIDTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_in    (char_in),
        .cfg_valid  (cfg_valid),
        .text_attr  (text_attr),
        .cmd        (dp_cmd),
        .st         (dp_st),
        .cmd_ready  (cmd_ready),
        .cmd_valid  (cmd_valid),
        .cmd_kind   (cmd_kind),
        .cell_addr  (cell_addr),
        .char_code  (char_code),
        .cell_attr  (cell_attr),
        .cursor_col (cursor_col),
        .cursor_row (cursor_row),
        .last       (last)
    );

endmodule

`default_nettype wire

/* rtl/core/tcew_dp.sv */
`default_nettype none

module tcew_dp #(
    parameter int COLUMNS   = tcew_pkg::COLUMNS_DEF,
    parameter int ROWS      = tcew_pkg::ROWS_DEF,
    parameter int TAB_WIDTH = tcew_pkg::TAB_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [tcew_pkg::CHAR_W-1:0]   char_in,
    input  wire logic                          cfg_valid,
    input  wire logic [tcew_pkg::ATTR_W-1:0]   text_attr,
    input  wire tcew_pkg::dp_cmd_t             cmd,
    output tcew_pkg::dp_status_t               st,
    input  wire logic                          cmd_ready,
    output logic                               cmd_valid,
    output logic [1:0]                         cmd_kind,
    output logic [tcew_pkg::ADDR_W-1:0]        cell_addr,
    output logic [tcew_pkg::CHAR_W-1:0]        char_code,
    output logic [tcew_pkg::ATTR_W-1:0]        cell_attr,
    output logic [tcew_pkg::COL_W-1:0]         cursor_col,
    output logic [tcew_pkg::ROW_W-1:0]         cursor_row,
    output logic                               last
);

    localparam int COL_W     = tcew_pkg::COL_W;
    localparam int ROW_W     = tcew_pkg::ROW_W;
    localparam int ADDR_W    = tcew_pkg::ADDR_W;
    localparam int PARAM_W   = tcew_pkg::PARAM_W;
    localparam int TAB_STOPS = tcew_pkg::COL_LIMIT / TAB_WIDTH;

    // Architectural state
    logic [COL_W-1:0]           col_reg, col_next;
    logic [ROW_W-1:0]           row_reg, row_next;
    tcew_pkg::esc_phase_t       phase_reg, phase_next;
    logic [PARAM_W-1:0]         p1_reg, p1_next;
    logic [PARAM_W-1:0]         p2_reg, p2_next;
    logic [tcew_pkg::ATTR_W-1:0] attr_reg;
    logic [tcew_pkg::CHAR_W-1:0] char_reg;

    // Output word register
    logic                        out_valid_reg, out_valid_next;
    tcew_pkg::cmd_kind_t         out_kind_reg;
    logic [ADDR_W-1:0]           out_addr_reg;
    logic [tcew_pkg::CHAR_W-1:0] out_char_reg;
    logic [tcew_pkg::ATTR_W-1:0] out_attr_reg;
    logic [COL_W-1:0]            out_col_reg;
    logic [ROW_W-1:0]            out_row_reg;
    logic                        out_last_reg;

    logic [COL_W:0]             col_inc;
    logic                       wrap_next;
    logic                       tab_stop;
    logic                       row_last;
    logic [ROW_W-1:0]           row_adv;
    logic [ADDR_W:0]            addr_full;
    logic [ADDR_W-1:0]          cur_addr;
    logic [PARAM_W-1:0]         p1_dig, p2_dig;
    logic [PARAM_W-1:0]         row_clamp, col_clamp;
    tcew_pkg::ch_class_t        ch_class;

    // Classify the held byte
    always_comb
    begin
        case (char_reg) inside
            tcew_pkg::CH_CR:               ch_class = tcew_pkg::CC_CR;
            tcew_pkg::CH_BS:               ch_class = tcew_pkg::CC_BS;
            tcew_pkg::CH_TAB:              ch_class = tcew_pkg::CC_TAB;
            tcew_pkg::CH_NL:               ch_class = tcew_pkg::CC_NL;
            tcew_pkg::CH_ESC:              ch_class = tcew_pkg::CC_ESC;
            tcew_pkg::CH_LBRACK:           ch_class = tcew_pkg::CC_LBRACK;
            [tcew_pkg::CH_0:tcew_pkg::CH_9]: ch_class = tcew_pkg::CC_DIGIT;
            tcew_pkg::CH_SEMI:             ch_class = tcew_pkg::CC_SEMI;
            tcew_pkg::CH_J:                ch_class = tcew_pkg::CC_J;
            tcew_pkg::CH_E:                ch_class = tcew_pkg::CC_E;
            tcew_pkg::CH_H:                ch_class = tcew_pkg::CC_H;
            default:                       ch_class = tcew_pkg::CC_OTHER;
        endcase
    end

    // Cursor neighborhood
    assign col_inc   = {1'b0, col_reg} + (COL_W+1)'(1);
    assign wrap_next = col_inc >= (COL_W+1)'(COLUMNS);
    assign row_last  = row_reg == ROW_W'(ROWS - 1);
    assign row_adv   = row_last ? row_reg : row_reg + ROW_W'(1);

    // Match the next column against every tab stop
    always_comb
    begin
        tab_stop = 1'b0;
        for (int k = 1; k <= TAB_STOPS; k++)
        begin
            if (col_inc == (COL_W+1)'(k * TAB_WIDTH))
            begin
                tab_stop = 1'b1;
            end
        end
    end

    // Cell address of the cursor, kept to the address width
    assign addr_full = (ADDR_W+1)'(row_reg) * (ADDR_W+1)'(COLUMNS) + (ADDR_W+1)'(col_reg);
    assign cur_addr  = addr_full[ADDR_W-1:0];

    // Accumulate a decimal digit, saturating
    function automatic logic [PARAM_W-1:0] add_digit(
        input logic [PARAM_W-1:0] p,
        input logic [3:0]         d
    );
        logic [PARAM_W+3:0] sum;
        sum = (PARAM_W+4)'(p) * (PARAM_W+4)'(10) + (PARAM_W+4)'(d);
        return (sum > (PARAM_W+4)'(tcew_pkg::PARAM_MAX)) ? tcew_pkg::PARAM_MAX
                                                          : sum[PARAM_W-1:0];
    endfunction

    // One-based parameter to zero-based position, held to the screen
    function automatic logic [PARAM_W-1:0] clamp_pos(
        input logic [PARAM_W-1:0] p,
        input logic [PARAM_W-1:0] size
    );
        logic [PARAM_W-1:0] m;
        m = p - PARAM_W'(1);
        if (p == '0)
        begin
            return '0;
        end
        return (m >= size) ? size - PARAM_W'(1) : m;
    endfunction

    assign p1_dig    = add_digit(p1_reg, char_reg[3:0]);
    assign p2_dig    = add_digit(p2_reg, char_reg[3:0]);
    assign row_clamp = clamp_pos(p1_reg, PARAM_W'(ROWS));
    assign col_clamp = clamp_pos(p2_reg, PARAM_W'(COLUMNS));

    // Cursor update
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        case (cmd.cur_op)
            tcew_pkg::CUR_ADV:
            begin
                if (wrap_next)
                begin
                    col_next = '0;
                    row_next = row_adv;
                end
                else
                begin
                    col_next = col_inc[COL_W-1:0];
                end
            end
            tcew_pkg::CUR_BACK:
            begin
                if (col_reg == '0)
                begin
                    col_next = COL_W'(COLUMNS - 1);
                    row_next = row_reg - ROW_W'(1);
                end
                else
                begin
                    col_next = col_reg - COL_W'(1);
                end
            end
            tcew_pkg::CUR_NEWLINE:
            begin
                col_next = '0;
                row_next = row_adv;
            end
            tcew_pkg::CUR_PARAM:
            begin
                col_next = col_clamp[COL_W-1:0];
                row_next = row_clamp[ROW_W-1:0];
            end
            default:
            begin
                col_next = col_reg;
                row_next = row_reg;
            end
        endcase
    end

    // Escape parameters
    always_comb
    begin
        p1_next = p1_reg;
        p2_next = p2_reg;
        case (cmd.par_op)
            tcew_pkg::PAR_CLR1: p1_next = '0;
            tcew_pkg::PAR_CLR2: p2_next = '0;
            tcew_pkg::PAR_DIG1: p1_next = p1_dig;
            tcew_pkg::PAR_DIG2: p2_next = p2_dig;
            default:
            begin
                p1_next = p1_reg;
                p2_next = p2_reg;
            end
        endcase
    end

    assign phase_next = cmd.set_phase ? cmd.phase_val : phase_reg;

    // Output word: set on emit, drop when taken
    always_comb
    begin
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (cmd_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            phase_reg     <= tcew_pkg::PH_TEXT;
            p1_reg        <= '0;
            p2_reg        <= '0;
            attr_reg      <= tcew_pkg::ATTR_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            phase_reg     <= phase_next;
            p1_reg        <= p1_next;
            p2_reg        <= p2_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                attr_reg <= text_attr;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_char)
        begin
            char_reg <= char_in;
        end
        if (cmd.emit)
        begin
            out_kind_reg <= cmd.emit_kind;
            out_col_reg  <= col_next;
            out_row_reg  <= row_next;
            out_last_reg <= cmd.emit_last;
            case (cmd.emit_kind)
                tcew_pkg::KIND_CELL:
                begin
                    out_addr_reg <= cur_addr;
                    out_char_reg <= cmd.use_space ? tcew_pkg::CH_SPACE : char_reg;
                    out_attr_reg <= attr_reg;
                end
                tcew_pkg::KIND_CLEAR:
                begin
                    out_addr_reg <= cur_addr;
                    out_char_reg <= '0;
                    out_attr_reg <= '0;
                end
                default:
                begin
                    out_addr_reg <= '0;
                    out_char_reg <= '0;
                    out_attr_reg <= '0;
                end
            endcase
        end
    end

    // Status to the controller
    assign st.ch_class      = ch_class;
    assign st.phase         = phase_reg;
    assign st.col_zero      = col_reg == '0;
    assign st.row_zero      = row_reg == '0;
    assign st.row_last      = row_last;
    assign st.wrap_next     = wrap_next;
    assign st.tab_stop_next = tab_stop;
    assign st.out_free      = !out_valid_reg || cmd_ready;

    assign cmd_valid  = out_valid_reg;
    assign cmd_kind   = out_kind_reg;
    assign cell_addr  = out_addr_reg;
    assign char_code  = out_char_reg;
    assign cell_attr  = out_attr_reg;
    assign cursor_col = out_col_reg;
    assign cursor_row = out_row_reg;
    assign last       = out_last_reg;

endmodule

`default_nettype wire

/* rtl/core/tcew_ctrl.sv */
`default_nettype none

module tcew_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  char_valid,
    output logic                       char_ready,
    input  wire tcew_pkg::dp_status_t  st,
    output tcew_pkg::dp_cmd_t          cmd
);

    tcew_pkg::ctrl_state_t state_reg, state_next;
    logic                  put;
    logic                  need_out;
    logic                  scroll;
    logic                  done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tcew_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = tcew_pkg::CMD_IDLE;
        state_next = state_reg;
        char_ready = 1'b0;
        put        = 1'b0;
        need_out   = 1'b0;
        scroll     = st.wrap_next && st.row_last;
        done       = st.tab_stop_next || st.wrap_next;

        case (state_reg)
            tcew_pkg::ST_IDLE:
            begin
                // Take the next byte
                char_ready = 1'b1;
                if (char_valid)
                begin
                    cmd.load_char = 1'b1;
                    state_next    = tcew_pkg::ST_DECODE;
                end
            end

            tcew_pkg::ST_DECODE:
            begin
                state_next = tcew_pkg::ST_IDLE;
                // Advance the escape parser
                case (st.phase)
                    tcew_pkg::PH_TEXT:
                    begin
                        if (st.ch_class == tcew_pkg::CC_ESC)
                        begin
                            cmd.set_phase = 1'b1;
                            cmd.phase_val = tcew_pkg::PH_ESC;
                        end
                        else
                        begin
                            put = 1'b1;
                        end
                    end
                    tcew_pkg::PH_ESC:
                    begin
                        cmd.set_phase = 1'b1;
                        if (st.ch_class == tcew_pkg::CC_LBRACK)
                        begin
                            cmd.phase_val = tcew_pkg::PH_P1;
                            cmd.par_op    = tcew_pkg::PAR_CLR1;
                        end
                        else
                        begin
                            cmd.phase_val = tcew_pkg::PH_TEXT;
                            put           = 1'b1;
                        end
                    end
                    tcew_pkg::PH_P1:
                    begin
                        if (st.ch_class == tcew_pkg::CC_DIGIT)
                        begin
                            cmd.par_op = tcew_pkg::PAR_DIG1;
                        end
                        else if (st.ch_class == tcew_pkg::CC_SEMI)
                        begin
                            cmd.set_phase = 1'b1;
                            cmd.phase_val = tcew_pkg::PH_P2;
                            cmd.par_op    = tcew_pkg::PAR_CLR2;
                        end
                        else
                        begin
                            cmd.set_phase = 1'b1;
                            cmd.phase_val = tcew_pkg::PH_TEXT;
                            if (st.ch_class == tcew_pkg::CC_J)
                            begin
                                need_out      = 1'b1;
                                cmd.emit      = 1'b1;
                                cmd.emit_kind = tcew_pkg::KIND_CLEAR;
                                cmd.emit_last = 1'b1;
                            end
                            else if (st.ch_class == tcew_pkg::CC_E)
                            begin
                                need_out      = 1'b1;
                                cmd.emit      = 1'b1;
                                cmd.emit_kind = tcew_pkg::KIND_ECHO;
                                cmd.emit_last = 1'b1;
                            end
                            else
                            begin
                                put = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        if (st.ch_class == tcew_pkg::CC_DIGIT)
                        begin
                            cmd.par_op = tcew_pkg::PAR_DIG2;
                        end
                        else
                        begin
                            cmd.set_phase = 1'b1;
                            cmd.phase_val = tcew_pkg::PH_TEXT;
                            if (st.ch_class == tcew_pkg::CC_H)
                            begin
                                cmd.cur_op = tcew_pkg::CUR_PARAM;
                            end
                            else
                            begin
                                put = 1'b1;
                            end
                        end
                    end
                endcase

                // Display the byte
                if (put)
                begin
                    case (st.ch_class)
                        tcew_pkg::CC_CR:
                        begin
                            state_next = tcew_pkg::ST_IDLE;
                        end
                        tcew_pkg::CC_BS:
                        begin
                            if (!(st.col_zero && st.row_zero))
                            begin
                                cmd.cur_op = tcew_pkg::CUR_BACK;
                                state_next = tcew_pkg::ST_BS_EMIT;
                            end
                        end
                        tcew_pkg::CC_TAB:
                        begin
                            state_next = tcew_pkg::ST_TAB;
                        end
                        tcew_pkg::CC_NL:
                        begin
                            cmd.cur_op = tcew_pkg::CUR_NEWLINE;
                            if (st.row_last)
                            begin
                                state_next = tcew_pkg::ST_SCROLL;
                            end
                        end
                        default:
                        begin
                            need_out      = 1'b1;
                            cmd.emit      = 1'b1;
                            cmd.emit_kind = tcew_pkg::KIND_CELL;
                            cmd.cur_op    = tcew_pkg::CUR_ADV;
                            cmd.emit_last = !scroll;
                            if (scroll)
                            begin
                                state_next = tcew_pkg::ST_SCROLL;
                            end
                        end
                    endcase
                end

                // Hold everything while the output word is still waiting
                if (need_out && !st.out_free)
                begin
                    cmd        = tcew_pkg::CMD_IDLE;
                    state_next = tcew_pkg::ST_DECODE;
                end
            end

            tcew_pkg::ST_TAB:
            begin
                // Write one space per cycle, while the output word is free, up to the next stop or the line end
                if (st.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = tcew_pkg::KIND_CELL;
                    cmd.use_space = 1'b1;
                    cmd.cur_op    = tcew_pkg::CUR_ADV;
                    cmd.emit_last = done && !scroll;
                    if (done)
                    begin
                        state_next = scroll ? tcew_pkg::ST_SCROLL : tcew_pkg::ST_IDLE;
                    end
                end
            end

            tcew_pkg::ST_BS_EMIT:
            begin
                // Blank the cell the cursor moved back to
                if (st.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = tcew_pkg::KIND_CELL;
                    cmd.use_space = 1'b1;
                    cmd.emit_last = 1'b1;
                    state_next    = tcew_pkg::ST_IDLE;
                end
            end

            tcew_pkg::ST_SCROLL:
            begin
                if (st.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = tcew_pkg::KIND_SCROLL;
                    cmd.emit_last = 1'b1;
                    state_next    = tcew_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = tcew_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire
